// ----- sv/rit_pkg.sv -----
package rit_pkg;

  typedef enum logic [2:0] {
    CMD_ALLOC = 3'd0,
    CMD_PUT   = 3'd1,
    CMD_FIND  = 3'd2,
    CMD_DONE  = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_NO_FREE  = 3'd2,
    STS_DUP      = 3'd3,
    STS_NOTFOUND = 3'd4,
    STS_RANK     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHUP,
    S_SHDN,
    S_WRITE
  } state_e;

  localparam logic CFG_MAX_OUT = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] request_id;
    logic [15:0] free_rank;
    logic [15:0] upstream_handle;
    logic [31:0] client_ip;
    logic [15:0] client_port;
    logic [15:0] original_id;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_id;
    logic [15:0] entry_upstream;
    logic [31:0] entry_ip;
    logic [15:0] entry_port;
    logic [15:0] entry_original;
    logic        timed_out;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] upstream;
    logic [31:0] ip;
    logic [15:0] port;
    logic [15:0] original;
    logic [31:0] expiry;
    logic        expiring;
  } entry_t;

endpackage

// ----- sv/rit_ram.sv -----
module rit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/request_id_table_with_timeout_core.sv -----
// Outstanding request table, kept sorted by ID in one single-port-read RAM
// that the controller walks one entry per cycle. A command is taken when
// start_i is high and busy_o low; every result appears for one cycle with
// res_valid_o and cannot be held off, so sample it when it comes. A refused
// allocate answers on the next cycle without going busy. A put that stores
// first shifts the entries above its slot one place up, then writes; done
// shifts the entries after its slot down after its result. A tick rescans
// the whole table for each expired entry, reports it and then closes the gap,
// and it ends with a closing result. The table needs no clearing pass after
// reset: only entries below the fill count are ever read.
module request_id_table_with_timeout_core
  import rit_pkg::*;
#(
  parameter int TABLE_DEPTH = 32,
  parameter int ID_BITS     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  req_t        req_i,
  output logic        res_valid_o,
  output res_t        res_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int AW = ID_BITS + 1;
  localparam int EW = $bits(entry_t);

  state_e state_q, state_d;
  logic [2:0]    op_q, op_d;
  req_t          req_q, req_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0]   now_q, now_d;
  logic [5:0]    max_q;
  logic [15:0]   tmo_q;
  logic [CW-1:0] idx_q, idx_d;
  logic          pv_q, pv_d;
  logic [IW-1:0] pidx_q, pidx_d;
  logic          found_q, found_d;
  logic [IW-1:0] pos_q, pos_d;
  logic [CW-1:0] at_q, at_d;
  logic [CW-1:0] sp_q, sp_d;
  entry_t        ent_q, ent_d;
  logic [31:0]   best_q, best_d;
  logic          stop_q, stop_d;
  logic [AW-1:0] aq_q, aq_d;
  logic [AW-1:0] anext_q, anext_d;
  logic          res_valid_q, res_valid_d;
  res_t          res_q, res_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, e;
  logic [EW-1:0] ram_rdata;

  rit_ram #(.WIDTH(EW), .DEPTH(1 << IW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign e = entry_t'(ram_rdata);

  logic          accept, full, scan_end, shup_end, shdn_end;
  logic [15:0]   rid;
  logic [AW-1:0] gap;
  logic [31:0]   age;

  assign accept   = start_i && (state_q == S_IDLE);
  assign full     = (cnt_q >= CW'(TABLE_DEPTH)) ||
                    ((max_q != 6'd0) && (7'(cnt_q) >= 7'(max_q)));
  assign scan_end = !pv_q && (idx_q >= cnt_q);
  assign shup_end = !pv_q && (sp_q <= at_q);
  assign shdn_end = !pv_q && (sp_q >= cnt_q);
  assign rid      = 16'(req_q.request_id[ID_BITS-1:0]);
  assign gap      = AW'(e.id[ID_BITS-1:0]) - anext_q;
  assign age      = now_q - e.expiry;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.command == CMD_PUT || req_i.command == CMD_FIND ||
              req_i.command == CMD_DONE || req_i.command == CMD_TICK) begin
            state_d = S_SCAN;
          end else if (req_i.command == CMD_ALLOC) begin
            if (!full && (17'(cnt_q) < (17'(1) << ID_BITS)) &&
                (17'(req_i.free_rank) < (17'(1) << ID_BITS) - 17'(cnt_q))) begin
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          priority if (op_q == CMD_PUT) begin
            if (found_q || full) state_d = S_IDLE;
            else if (at_q == cnt_q) state_d = S_WRITE;
            else state_d = S_SHUP;
          end else if (op_q == CMD_DONE || op_q == CMD_TICK) begin
            state_d = found_q ? S_SHDN : S_IDLE;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SHUP:  if (shup_end) state_d = S_WRITE;
      S_SHDN:  if (shdn_end) state_d = (op_q == CMD_TICK) ? S_SCAN : S_IDLE;
      S_WRITE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    op_d = op_q; req_d = req_q; cnt_d = cnt_q; now_d = now_q;
    idx_d = idx_q; pv_d = 1'b0; pidx_d = pidx_q; found_d = found_q;
    pos_d = pos_q; at_d = at_q; sp_d = sp_q; ent_d = ent_q; best_d = best_q;
    stop_d = stop_q; aq_d = aq_q; anext_d = anext_q;
    res_valid_d = 1'b0;
    res_d = '0;
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = ent_q; ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = req_i.command; req_d = req_i;
          idx_d = '0; found_d = 1'b0; at_d = '0; stop_d = 1'b0;
          aq_d = AW'(req_i.free_rank); anext_d = '0;
          if (req_i.command == CMD_TICK) now_d = now_q + 32'd1;
          if (req_i.command == CMD_ALLOC) begin
            res_d.last = 1'b1;
            priority if (full) begin
              res_valid_d = 1'b1; res_d.status = STS_FULL;
            end else if (17'(cnt_q) >= (17'(1) << ID_BITS)) begin
              res_valid_d = 1'b1; res_d.status = STS_NO_FREE;
            end else if (17'(req_i.free_rank) >=
                         (17'(1) << ID_BITS) - 17'(cnt_q)) begin
              res_valid_d = 1'b1; res_d.status = STS_RANK;
            end else begin
              res_d.last = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        if (idx_q < cnt_q) begin
          ram_raddr = idx_q[IW-1:0];
          pv_d = 1'b1; pidx_d = idx_q[IW-1:0]; idx_d = idx_q + CW'(1);
        end
        if (pv_q) begin
          priority if (op_q == CMD_ALLOC) begin
            if (!stop_q) begin
              if (aq_q < gap) stop_d = 1'b1;
              else begin
                aq_d = aq_q - gap;
                anext_d = AW'(e.id[ID_BITS-1:0]) + AW'(1);
              end
            end
          end else if (op_q == CMD_PUT) begin
            if (e.id == rid) found_d = 1'b1;
            if (e.id < rid) at_d = at_q + CW'(1);
          end else if (op_q == CMD_TICK) begin
            // strict compare keeps the lower slot, hence the smaller ID, on ties
            if (e.expiring && !age[31] && (!found_q || age > best_q)) begin
              found_d = 1'b1; pos_d = pidx_q; ent_d = e; best_d = age;
            end
          end else begin
            if (e.id == rid) begin
              found_d = 1'b1; pos_d = pidx_q; ent_d = e;
            end
          end
        end
        if (scan_end) begin
          res_valid_d = 1'b1;
          res_d.last = 1'b1;
          priority if (op_q == CMD_ALLOC) begin
            res_d.status = STS_OK;
            res_d.result_id = 16'(aq_q[ID_BITS-1:0] + anext_q[ID_BITS-1:0]);
          end else if (op_q == CMD_PUT) begin
            res_valid_d = 1'b0;
            if (found_q) begin
              res_valid_d = 1'b1; res_d.status = STS_DUP;
            end else if (full) begin
              res_valid_d = 1'b1; res_d.status = STS_FULL;
            end else begin
              ent_d.id = rid;
              ent_d.upstream = req_q.upstream_handle;
              ent_d.ip = req_q.client_ip;
              ent_d.port = req_q.client_port;
              ent_d.original = req_q.original_id;
              ent_d.expiry = now_q + 32'(tmo_q);
              ent_d.expiring = (tmo_q != 16'd0);
              sp_d = cnt_q;
            end
          end else if (!found_q) begin
            res_d.status = (op_q == CMD_TICK) ? STS_OK : STS_NOTFOUND;
          end else begin
            res_d.status = STS_OK;
            res_d.result_id = ent_q.id;
            res_d.entry_upstream = ent_q.upstream;
            res_d.entry_ip = ent_q.ip;
            res_d.entry_port = ent_q.port;
            res_d.entry_original = ent_q.original;
            res_d.timed_out = (op_q == CMD_TICK);
            res_d.last = (op_q != CMD_TICK);
            sp_d = CW'(pos_q) + CW'(1);
            if (op_q == CMD_FIND) res_d.last = 1'b1;
          end
        end
      end
      S_SHUP: begin
        // walk downwards: read slot sp-1, write it one place up
        if (sp_q > at_q) begin
          ram_raddr = IW'(sp_q - CW'(1));
          pv_d = 1'b1; pidx_d = IW'(sp_q - CW'(1)); sp_d = sp_q - CW'(1);
        end
        if (pv_q) begin
          ram_we = 1'b1; ram_waddr = IW'(pidx_q + IW'(1)); ram_wdata = e;
        end
      end
      S_SHDN: begin
        if (sp_q < cnt_q) begin
          ram_raddr = sp_q[IW-1:0];
          pv_d = 1'b1; pidx_d = sp_q[IW-1:0]; sp_d = sp_q + CW'(1);
        end
        if (pv_q) begin
          ram_we = 1'b1; ram_waddr = IW'(pidx_q - IW'(1)); ram_wdata = e;
        end
        if (shdn_end) begin
          cnt_d = cnt_q - CW'(1);
          idx_d = '0; found_d = 1'b0;
        end
      end
      S_WRITE: begin
        ram_we = 1'b1; ram_waddr = at_q[IW-1:0]; ram_wdata = ent_q;
        cnt_d = cnt_q + CW'(1);
        res_valid_d = 1'b1;
        res_d.status = STS_OK;
        res_d.result_id = ent_q.id;
        res_d.entry_upstream = ent_q.upstream;
        res_d.entry_ip = ent_q.ip;
        res_d.entry_port = ent_q.port;
        res_d.entry_original = ent_q.original;
        res_d.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      now_q       <= '0;
      max_q       <= '0;
      tmo_q       <= '0;
      pv_q        <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      now_q       <= now_d;
      pv_q        <= pv_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i && cfg_idx_i == CFG_MAX_OUT) max_q <= cfg_wdata_i[5:0];
      if (cfg_we_i && cfg_idx_i == CFG_TIMEOUT) tmo_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    req_q   <= req_d;
    idx_q   <= idx_d;
    pidx_q  <= pidx_d;
    found_q <= found_d;
    pos_q   <= pos_d;
    at_q    <= at_d;
    sp_q    <= sp_d;
    ent_q   <= ent_d;
    best_q  <= best_d;
    stop_q  <= stop_d;
    aq_q    <= aq_d;
    anext_q <= anext_d;
    res_q   <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> !pv_q) else $error("read in flight while idle");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH)) else $error("fill count beyond depth");

  a_tick_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.command == CMD_TICK |=> now_q == $past(now_q) + 32'd1)
    else $error("tick did not advance time");

  a_write_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE |=> cnt_q == $past(cnt_q) + CW'(1) && res_valid_o)
    else $error("insert did not store and report");

endmodule

// ----- verif/tb.sv -----
module tb;
  import rit_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam int IDLE_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  req_t        req_i = '0;
  logic        res_valid_o;
  res_t        res_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  request_id_table_with_timeout_core u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i,
    .res_valid_o, .res_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #4 clk_i = ~clk_i;

  // shadow of the table, sorted by ID
  entry_t    shadow[$];
  logic [31:0] clock_ticks;
  logic [5:0]  limit_cfg;
  logic [15:0] timeout_cfg;

  res_t expected_results[$];
  int   mismatches;
  int   idle_cycles;
  int   send_idle_pct;

  function automatic res_t make_res(logic [2:0] st, entry_t e, logic with_e,
                                    logic tmo, logic lst);
    res_t r;
    r = '0;
    r.status = st;
    if (with_e) begin
      r.result_id = e.id;
      r.entry_upstream = e.upstream;
      r.entry_ip = e.ip;
      r.entry_port = e.port;
      r.entry_original = e.original;
    end
    r.timed_out = tmo;
    r.last = lst;
    return r;
  endfunction

  function automatic logic table_full();
    return shadow.size() >= DEPTH ||
           (limit_cfg != 0 && shadow.size() >= limit_cfg);
  endfunction

  function automatic int find_slot(logic [15:0] id);
    foreach (shadow[i]) if (shadow[i].id == id) return i;
    return -1;
  endfunction

  // advance the shadow table by one command and queue what it must emit
  task automatic predict_table(req_t rq);
    entry_t e;
    int     pos;
    int     best;
    logic [31:0] age, best_age;
    logic [16:0] rank, nxt, gap;
    e = '0;
    case (rq.command)
      CMD_ALLOC: begin
        if (table_full())
          expected_results.push_back(make_res(STS_FULL, e, 1'b0, 1'b0, 1'b1));
        else if (rq.free_rank >= 17'h10000 - shadow.size())
          expected_results.push_back(make_res(STS_RANK, e, 1'b0, 1'b0, 1'b1));
        else begin
          rank = 17'(rq.free_rank);
          nxt = '0;
          foreach (shadow[i]) begin
            gap = 17'(shadow[i].id) - nxt;
            if (rank < gap) break;
            rank -= gap;
            nxt = 17'(shadow[i].id) + 17'd1;
          end
          e.id = 16'(rank + nxt);
          expected_results.push_back(make_res(STS_OK, e, 1'b1, 1'b0, 1'b1));
        end
      end
      CMD_PUT: begin
        if (find_slot(rq.request_id) >= 0)
          expected_results.push_back(make_res(STS_DUP, e, 1'b0, 1'b0, 1'b1));
        else if (table_full())
          expected_results.push_back(make_res(STS_FULL, e, 1'b0, 1'b0, 1'b1));
        else begin
          e.id = rq.request_id;
          e.upstream = rq.upstream_handle;
          e.ip = rq.client_ip;
          e.port = rq.client_port;
          e.original = rq.original_id;
          e.expiry = clock_ticks + 32'(timeout_cfg);
          e.expiring = timeout_cfg != 0;
          pos = 0;
          while (pos < shadow.size() && shadow[pos].id < e.id) pos++;
          shadow.insert(pos, e);
          expected_results.push_back(make_res(STS_OK, e, 1'b1, 1'b0, 1'b1));
        end
      end
      CMD_FIND, CMD_DONE: begin
        pos = find_slot(rq.request_id);
        if (pos < 0)
          expected_results.push_back(make_res(STS_NOTFOUND, e, 1'b0, 1'b0, 1'b1));
        else begin
          expected_results.push_back(make_res(STS_OK, shadow[pos], 1'b1, 1'b0, 1'b1));
          if (rq.command == CMD_DONE) shadow.delete(pos);
        end
      end
      CMD_TICK: begin
        clock_ticks++;
        forever begin
          best = -1;
          best_age = 0;
          foreach (shadow[i]) begin
            age = clock_ticks - shadow[i].expiry;
            if (!shadow[i].expiring || age[31]) continue;
            if (best < 0 || age > best_age) begin
              best = i;
              best_age = age;
            end
          end
          if (best < 0) break;
          expected_results.push_back(make_res(STS_OK, shadow[best], 1'b1, 1'b1, 1'b0));
          shadow.delete(best);
        end
        expected_results.push_back(make_res(STS_OK, e, 1'b0, 1'b0, 1'b1));
      end
      default: ;
    endcase
  endtask

  task automatic send_command(req_t rq);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    start_i <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_table(rq);
    start_i <= 1'b0;
    req_i <= '0;
    @(posedge clk_i);
  endtask

  function automatic req_t rand_req(logic [2:0] cmd);
    req_t r;
    r.command = cmd;
    r.request_id = 16'($urandom);
    r.free_rank = 16'($urandom);
    r.upstream_handle = 16'($urandom);
    r.client_ip = $urandom;
    r.client_port = 16'($urandom);
    r.original_id = 16'($urandom);
    return r;
  endfunction

  function automatic req_t id_req(logic [2:0] cmd, logic [15:0] id);
    req_t r;
    r = rand_req(cmd);
    r.request_id = id;
    return r;
  endfunction

  task automatic drain_results();
    while (expected_results.size() != 0) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    repeat (2 * DEPTH + 8) @(posedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [15:0] val);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAX_OUT) limit_cfg = val[5:0];
    else timeout_cfg = val;
  endtask

  task automatic test_directed();
    req_t r;
    send_command(rand_req(CMD_TICK));
    send_command(id_req(CMD_FIND, 16'h0000));
    send_command(id_req(CMD_DONE, 16'hffff));
    r = rand_req(CMD_ALLOC);
    r.free_rank = 16'h0000;
    send_command(r);
    r.free_rank = 16'hffff;
    send_command(r);
    r = id_req(CMD_PUT, 16'h0000);
    r.upstream_handle = '1;
    r.client_ip = '1;
    r.client_port = '1;
    r.original_id = '1;
    send_command(r);
    send_command(id_req(CMD_PUT, 16'hffff));
    send_command(id_req(CMD_PUT, 16'h0005));
    send_command(id_req(CMD_PUT, 16'h0005));
    r = rand_req(CMD_ALLOC);
    r.free_rank = 16'hfffc;
    send_command(r);
    r.free_rank = 16'hfffd;
    send_command(r);
    r.free_rank = 16'h0004;
    send_command(r);
    send_command(id_req(CMD_FIND, 16'h0005));
    send_command(id_req(CMD_DONE, 16'h0005));
    send_command(id_req(CMD_FIND, 16'h0005));
    send_command(rand_req(3'd5));
    send_command(rand_req(3'd7));
    send_command(rand_req(CMD_TICK));
  endtask

  // fill to the limit, then check the full refusals
  task automatic test_limits(logic [5:0] lim);
    int n;
    n = (lim == 6'd0) ? DEPTH + 1 : int'(lim) + 1;
    write_register(CFG_MAX_OUT, {10'd0, lim});
    for (int i = 0; i < n; i++) send_command(id_req(CMD_PUT, 16'(3 * i + 1)));
    send_command(rand_req(CMD_ALLOC));
    send_command(id_req(CMD_PUT, 16'hfff0));
  endtask

  task automatic clear_table();
    entry_t snap[$];
    snap = shadow;
    foreach (snap[i]) send_command(id_req(CMD_DONE, snap[i].id));
  endtask

  task automatic test_expiry(logic [15:0] tmo, int n);
    write_register(CFG_TIMEOUT, tmo);
    repeat (n) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_command(id_req(CMD_PUT, 16'($urandom_range(80, 0))));
        4:          send_command(rand_req(CMD_ALLOC));
        5:          send_command(id_req(CMD_FIND, 16'($urandom_range(80, 0))));
        6:          send_command(id_req(CMD_DONE, 16'($urandom_range(80, 0))));
        7:          send_command(rand_req(3'($urandom_range(7))));
        default:    send_command(rand_req(CMD_TICK));
      endcase
    end
  endtask

  initial begin
    limit_cfg = 0;
    timeout_cfg = 0;
    clock_ticks = 0;
    mismatches = 0;
    send_idle_pct = 34;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limits(6'd4);
    clear_table();
    test_limits(6'd0);
    clear_table();
    test_limits(6'd20);
    clear_table();
    write_register(CFG_MAX_OUT, 16'd0);
    test_expiry(16'd3, 15);
    drain_results();
    send_idle_pct = 53;
    test_expiry(16'd1, 10);
    send_idle_pct = 0;
    test_expiry(16'hffff, 8);
    test_expiry(16'd0, 7);
    repeat (4) send_command(rand_req(CMD_TICK));
    drain_results();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", res_o);
      end else if (res_o !== expected_results[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h got %h", expected_results[0], res_o);
        void'(expected_results.pop_front());
      end else begin
        void'(expected_results.pop_front());
      end
    end
  end

  // watchdog: count cycles with no accepted command, result or register write
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule

// ----- files.f -----
sv/rit_pkg.sv
sv/rit_ram.sv
sv/request_id_table_with_timeout_core.sv
verif/tb.sv
